@@ rtl/core/jse_pkg.sv @@
// Shared types, constants and character functions for the JSON string escaper.
package jse_pkg;

  // Default depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // Output slots of one request: quote, two held bytes, six body characters, quote.
  localparam int SLOT_COUNT = 10;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int SLOT_OPEN  = 0;
  localparam int SLOT_HELD0 = 1;
  localparam int SLOT_HELD1 = 2;
  localparam int SLOT_BODY  = 3;
  localparam int SLOT_CLOSE = 9;

  // Character codes.
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_SEQ0      = 8'hE2;
  localparam logic [7:0] CH_SEQ1      = 8'h80;
  localparam logic [7:0] CH_LS        = 8'hA8;
  localparam logic [7:0] CH_PS        = 8'hA9;
  localparam logic [7:0] CH_BS        = 8'h08;
  localparam logic [7:0] CH_FF        = 8'h0C;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LOWER_B   = 8'h62;
  localparam logic [7:0] CH_LOWER_F   = 8'h66;
  localparam logic [7:0] CH_LOWER_N   = 8'h6E;
  localparam logic [7:0] CH_LOWER_R   = 8'h72;
  localparam logic [7:0] CH_LOWER_T   = 8'h74;
  localparam logic [7:0] CH_LOWER_U   = 8'h75;
  localparam logic [7:0] CH_DIGIT0    = 8'h30;
  localparam logic [7:0] CH_DIGIT2    = 8'h32;
  localparam logic [7:0] CH_DIGIT8    = 8'h38;
  localparam logic [7:0] CH_DIGIT9    = 8'h39;
  localparam logic [7:0] HEX_ALPHA_OFS = 8'h57;  // 'a' minus ten
  localparam logic [3:0] NIBBLE_MASK  = 4'hF;

  // Held-count codes.
  localparam logic [1:0] HELD_NONE = 2'd0;
  localparam logic [1:0] HELD_ONE  = 2'd1;
  localparam logic [1:0] HELD_TWO  = 2'd2;

  // How the byte of a request is written out.
  typedef enum logic [2:0] {
    BODY_NONE,
    BODY_PLAIN,
    BODY_PAIR,
    BODY_U00,
    BODY_U20
  } body_kind_t;

  // One classified request handed from the front part to the back part.
  typedef struct packed {
    logic       open_quote;
    logic [1:0] flush_n;
    body_kind_t kind;
    logic [7:0] ch;
    logic       close_quote;
  } job_t;

  typedef logic [SLOT_COUNT-1:0] slot_mask_t;

  // Lower-case hex digit of a nibble.
  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] n8;
    n8 = {4'b0000, n & NIBBLE_MASK};
    return (n < 4'd10) ? (CH_DIGIT0 + n8) : (HEX_ALPHA_OFS + n8);
  endfunction

  // Number of body characters of each kind, as a mask over the body slots.
  function automatic logic [5:0] body_mask(input body_kind_t kind);
    case (kind)
      BODY_PLAIN: body_mask = 6'b000001;
      BODY_PAIR:  body_mask = 6'b000011;
      BODY_U00:   body_mask = 6'b111111;
      BODY_U20:   body_mask = 6'b111111;
      default:    body_mask = 6'b000000;
    endcase
  endfunction

  // Character at body position k of a request.
  function automatic logic [7:0] body_char(input body_kind_t kind, input logic [7:0] ch,
                                           input logic [2:0] k);
    logic [7:0] c;
    c = ch;
    case (kind)
      BODY_PLAIN: c = ch;
      BODY_PAIR:  c = (k == 3'd0) ? CH_BACKSLASH : ch;
      BODY_U00: begin
        case (k)
          3'd0:    c = CH_BACKSLASH;
          3'd1:    c = CH_LOWER_U;
          3'd2:    c = CH_DIGIT0;
          3'd3:    c = CH_DIGIT0;
          3'd4:    c = hex_digit(ch[7:4]);
          default: c = hex_digit(ch[3:0]);
        endcase
      end
      BODY_U20: begin
        case (k)
          3'd0:    c = CH_BACKSLASH;
          3'd1:    c = CH_LOWER_U;
          3'd2:    c = CH_DIGIT2;
          3'd3:    c = CH_DIGIT0;
          3'd4:    c = CH_DIGIT2;
          default: c = (ch == CH_PS) ? CH_DIGIT9 : CH_DIGIT8;
        endcase
      end
      default: c = ch;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/core/jse_front.sv @@
// Front part: accepts input bytes, tracks held sequence bytes and classifies each request.
module jse_front
  import jse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] byte_value,
  input  logic       byte_present,
  input  logic       first_of_string,
  input  logic       last_of_string,
  input  logic       queue_full,
  output logic       push,
  output job_t       job
);

  logic [1:0] held_count;
  logic [1:0] held_count_next;
  logic [1:0] held_in;
  logic [1:0] held_mid;
  logic [1:0] pre_flush;
  logic       accept;
  logic       is_escape;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  // A byte that must be written as a backslash escape.
  assign is_escape = (byte_value < CH_SPACE) || (byte_value == CH_QUOTE) ||
                     (byte_value == CH_BACKSLASH);

  // Held count seen by this request; an impossible code or a new string clears it.
  always_comb begin
    held_in = held_count;
    if (held_count != HELD_NONE && held_count != HELD_ONE && held_count != HELD_TWO) begin
      held_in = HELD_NONE;
    end
    if (first_of_string) begin
      held_in = HELD_NONE;
    end
  end

  // Classify the byte against what is held.
  always_comb begin
    logic fresh;
    fresh     = 1'b0;
    held_mid  = held_in;
    pre_flush = HELD_NONE;
    job.kind  = BODY_NONE;
    job.ch    = byte_value;
    if (byte_present) begin
      held_mid = HELD_NONE;
      if (held_in == HELD_ONE) begin
        if (byte_value == CH_SEQ1 && !last_of_string) begin
          held_mid = HELD_TWO;
        end else begin
          pre_flush = HELD_ONE;
          fresh     = 1'b1;
        end
      end else if (held_in == HELD_TWO) begin
        if (byte_value == CH_LS || byte_value == CH_PS) begin
          job.kind = BODY_U20;
        end else begin
          pre_flush = HELD_TWO;
          fresh     = 1'b1;
        end
      end else begin
        fresh = 1'b1;
      end
      if (fresh) begin
        if (is_escape) begin
          job.kind = BODY_PAIR;
          case (byte_value)
            CH_QUOTE:     job.ch = CH_QUOTE;
            CH_BACKSLASH: job.ch = CH_BACKSLASH;
            CH_BS:        job.ch = CH_LOWER_B;
            CH_FF:        job.ch = CH_LOWER_F;
            CH_LF:        job.ch = CH_LOWER_N;
            CH_CR:        job.ch = CH_LOWER_R;
            CH_TAB:       job.ch = CH_LOWER_T;
            default:      job.kind = BODY_U00;
          endcase
        end else if (byte_value == CH_SEQ0 && !last_of_string) begin
          held_mid = HELD_ONE;
        end else begin
          job.kind = BODY_PLAIN;
        end
      end
    end
  end

  // Flushed bytes come before the body, or before the closing quote when no byte comes.
  always_comb begin
    job.open_quote  = first_of_string;
    job.close_quote = last_of_string;
    if (byte_present) begin
      job.flush_n = pre_flush;
    end else if (last_of_string) begin
      job.flush_n = held_in;
    end else begin
      job.flush_n = HELD_NONE;
    end
    held_count_next = last_of_string ? HELD_NONE : held_mid;
  end

  // Requests that put out nothing are not queued.
  assign push = accept && (job.open_quote || job.close_quote ||
                           job.flush_n != HELD_NONE || job.kind != BODY_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= HELD_NONE;
    end else if (accept) begin
      held_count <= held_count_next;
    end
  end

endmodule

@@ rtl/core/jse_queue.sv @@
// Small first-in first-out queue of classified requests between the front and back parts.
module jse_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == FULL_CNT);
  assign empty     = (count == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_data = entries[rd_ptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/jse_back.sv @@
// Back part: expands requests to characters, one per cycle if out_ready is high.
module jse_back
  import jse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       queue_empty,
  input  job_t       head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       last_of_run
);

  // Request being expanded.
  logic             work_valid;
  slot_mask_t       work_mask;
  body_kind_t       work_kind;
  logic [7:0]       work_ch;

  slot_mask_t       head_mask;
  slot_mask_t       rest_mask;
  logic [SLOT_W-1:0] slot;
  logic [7:0]       slot_char;
  logic             out_free;
  logic             emit;
  logic             done;

  // Slot mask of the request at the head of the queue.
  always_comb begin
    head_mask                    = '0;
    head_mask[SLOT_OPEN]         = head.open_quote;
    head_mask[SLOT_HELD0]        = (head.flush_n == HELD_ONE) || (head.flush_n == HELD_TWO);
    head_mask[SLOT_HELD1]        = (head.flush_n == HELD_TWO);
    head_mask[SLOT_BODY +: 6]    = body_mask(head.kind);
    head_mask[SLOT_CLOSE]        = head.close_quote;
  end

  // Lowest remaining slot is the next character.
  always_comb begin
    slot = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (work_mask[i]) begin
        slot = SLOT_W'(i);
      end
    end
    rest_mask       = work_mask;
    rest_mask[slot] = 1'b0;
  end

  // Character of the chosen slot.
  always_comb begin
    if (slot == SLOT_W'(SLOT_OPEN) || slot == SLOT_W'(SLOT_CLOSE)) begin
      slot_char = CH_QUOTE;
    end else if (slot == SLOT_W'(SLOT_HELD0)) begin
      slot_char = CH_SEQ0;
    end else if (slot == SLOT_W'(SLOT_HELD1)) begin
      slot_char = CH_SEQ1;
    end else begin
      slot_char = body_char(work_kind, work_ch, 3'(slot - SLOT_W'(SLOT_BODY)));
    end
  end

  assign out_free = !out_valid || out_ready;
  assign emit     = work_valid && out_free;
  assign done     = emit && (rest_mask == '0);
  assign pop      = (!work_valid || done) && !queue_empty;

  // Working register.
  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
    end else if (pop) begin
      work_valid <= 1'b1;
    end else if (done) begin
      work_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      work_mask <= head_mask;
      work_kind <= head.kind;
      work_ch   <= head.ch;
    end else if (emit) begin
      work_mask <= rest_mask;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char    <= slot_char;
      last_of_run <= (rest_mask == '0);
    end
  end

endmodule

@@ rtl/core/json_string_escaper_unit.sv @@
// Top level of the JSON string escaper: front classifier, request queue and back expander.
// A request's first character goes through the queue, the working and the output register.
// Throughput: one output character per cycle while m_tready is high, set by the back
// expander; a byte yields one character, an escape two or six, a quote or flushed byte one.
// The input is taken while the request queue has room; a full queue is its only stall.
// Reset (rst, synchronous): clears the held count, the queue and both valid registers.
module json_string_escaper_unit
  import jse_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] byte_value
  input  logic [1:0] s_tuser,   // [0] byte_present, [1] first_of_string
  input  logic       s_tlast,   // last_of_string
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_char
  output logic       m_tlast    // last_of_run
);

  job_t front_job;
  job_t head_job;
  logic push;
  logic pop;
  logic queue_full;
  logic queue_empty;

  // Classify incoming bytes.
  jse_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (s_tvalid),
    .in_ready        (s_tready),
    .byte_value      (s_tdata),
    .byte_present    (s_tuser[0]),
    .first_of_string (s_tuser[1]),
    .last_of_string  (s_tlast),
    .queue_full      (queue_full),
    .push            (push),
    .job             (front_job)
  );

  // Decouple the two parts.
  jse_queue #(
    .WIDTH ($bits(job_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_job),
    .pop       (pop),
    .head_data (head_job),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  // Expand requests into characters.
  jse_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .head        (head_job),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_char    (m_tdata),
    .last_of_run (m_tlast)
  );

endmodule
